// ===== hw/rtl/hsv2rgb_pkg.sv =====
// hsv2rgb_pkg: shared types and constants for the HSV to RGB pipeline.
// No dependencies; imported by hsv_to_rgb_converter, hsv2rgb_front/mix/quant.

package hsv2rgb_pkg;

  localparam logic [14:0] FULL_TURN   = 15'd23040;  // 360 deg, 1/64 deg units
  localparam logic [14:0] SECTOR_SPAN = 15'd3840;   // 60 deg
  localparam logic [8:0]  ONE_FIX     = 9'd256;     // 1.0 for s and v
  localparam logic [27:0] SEC_UNITS   = 28'd3840;
  localparam logic [36:0] CHAN_SCALE  = 37'd510;    // 255 * 2
  localparam logic [36:0] CHAN_BIAS   = 37'd251658240; // 3840 * 65536
  localparam logic [23:0] RECIP_15    = 24'd2185;   // ~2^15 / 15

  typedef enum logic [2:0] {
    SEC_CX0 = 3'd0,
    SEC_XC0 = 3'd1,
    SEC_0CX = 3'd2,
    SEC_0XC = 3'd3,
    SEC_X0C = 3'd4,
    SEC_C0X = 3'd5
  } sector_e;

  typedef struct packed {
    logic        inv;
    sector_e     sec;
    logic [11:0] k;
    logic [16:0] sv;
    logic [16:0] z;
  } front_t;

  typedef struct packed {
    logic             inv;
    logic [2:0][11:0] y;   // red, green, blue quotients by 2^25
  } mix_t;

endpackage

// ===== hw/rtl/hsv2rgb_if.sv =====
// hsv2rgb_if: valid/ready channel interfaces for HSV items in and RGB items out.
// No dependencies.

interface hsv2rgb_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] hue;
  logic [8:0]         saturation;
  logic [8:0]         brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] rgb;
  logic        invalid;

  modport source (output valid, rgb, invalid, input ready);
  modport sink   (input valid, rgb, invalid, output ready);
endinterface

// ===== hw/rtl/hsv_to_rgb_converter.sv =====
// hsv_to_rgb_converter: HSV pixel to packed 24-bit RGB, five register stages.
// Stage registers A to E lie in order between input acceptance and result valid.
// Throughput: one item per cycle; each stage holds under backpressure.
// Reset: rst_ni async, active low, clears all stage valid bits; no data reset.
// Depends on hsv2rgb_pkg, hsv2rgb_if, hsv2rgb_front, hsv2rgb_mix, hsv2rgb_quant.

module hsv_to_rgb_converter import hsv2rgb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  hsv2rgb_in_if.sink         pix_i,
  hsv2rgb_out_if.source      pix_o
);

  logic   fr_valid, fr_ready;
  front_t fr_data;
  logic   mx_valid, mx_ready;
  mix_t   mx_data;

  hsv2rgb_front u_front (
    .clk_i,
    .rst_ni,
    .valid_i      (pix_i.valid),
    .ready_o      (pix_i.ready),
    .hue_i        (pix_i.hue),
    .saturation_i (pix_i.saturation),
    .brightness_i (pix_i.brightness),
    .valid_o      (fr_valid),
    .ready_i      (fr_ready),
    .data_o       (fr_data)
  );

  hsv2rgb_mix u_mix (
    .clk_i,
    .rst_ni,
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .data_i  (fr_data),
    .valid_o (mx_valid),
    .ready_i (mx_ready),
    .data_o  (mx_data)
  );

  hsv2rgb_quant u_quant (
    .clk_i,
    .rst_ni,
    .valid_i   (mx_valid),
    .ready_o   (mx_ready),
    .data_i    (mx_data),
    .valid_o   (pix_o.valid),
    .ready_i   (pix_o.ready),
    .rgb_o     (pix_o.rgb),
    .invalid_o (pix_o.invalid)
  );

endmodule

// ===== hw/rtl/hsv2rgb_front.sv =====
// hsv2rgb_front: stages A and B - range check, hue wrap, s*v, sector and ramp.
// Depends on hsv2rgb_pkg.

module hsv2rgb_front import hsv2rgb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic signed [15:0] hue_i,
  input  logic [8:0]         saturation_i,
  input  logic [8:0]         brightness_i,
  output logic               valid_o,
  input  logic               ready_i,
  output front_t             data_o
);

  logic        a_vld_q, a_inv_q, a_inv_d;
  logic [14:0] a_h_q, a_h_d;
  logic [16:0] a_sv_q, a_sv_d;
  logic [8:0]  a_v_q;
  logic        b_vld_q;
  front_t      b_q, b_d;
  logic        en_a, en_b;
  logic [14:0] base;
  logic [12:0] t;

  assign en_b    = !b_vld_q || ready_i;
  assign en_a    = !a_vld_q || en_b;
  assign ready_o = en_a;

  always_comb begin
    a_inv_d = hue_i[15] || (saturation_i > ONE_FIX) || (brightness_i > ONE_FIX);
    a_h_d   = (hue_i[14:0] > FULL_TURN) ? (hue_i[14:0] - FULL_TURN) : hue_i[14:0];
    a_sv_d  = 17'(saturation_i) * 17'(brightness_i);
  end

  always_comb begin
    b_d.inv = a_inv_q;
    b_d.sv  = a_sv_q;
    b_d.z   = {a_v_q, 8'd0} - a_sv_q;
    priority if (a_h_q >= FULL_TURN) begin
      b_d.sec = SEC_CX0;
      base    = FULL_TURN;
    end else if (a_h_q >= 5 * SECTOR_SPAN) begin
      b_d.sec = SEC_C0X;
      base    = 15'(4 * SECTOR_SPAN);
    end else if (a_h_q >= 4 * SECTOR_SPAN) begin
      b_d.sec = SEC_X0C;
      base    = 15'(4 * SECTOR_SPAN);
    end else if (a_h_q >= 3 * SECTOR_SPAN) begin
      b_d.sec = SEC_0XC;
      base    = 15'(2 * SECTOR_SPAN);
    end else if (a_h_q >= 2 * SECTOR_SPAN) begin
      b_d.sec = SEC_0CX;
      base    = 15'(2 * SECTOR_SPAN);
    end else if (a_h_q >= SECTOR_SPAN) begin
      b_d.sec = SEC_XC0;
      base    = '0;
    end else begin
      b_d.sec = SEC_CX0;
      base    = '0;
    end
    t = 13'(a_h_q - base);
    b_d.k = (t < 13'(SECTOR_SPAN)) ? t[11:0] : 12'(13'(2 * SECTOR_SPAN) - t);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (en_a) a_vld_q <= valid_i;
      if (en_b) b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && valid_i) begin
      a_inv_q <= a_inv_d;
      a_h_q   <= a_h_d;
      a_sv_q  <= a_sv_d;
      a_v_q   <= brightness_i;
    end
    if (en_b && a_vld_q) b_q <= b_d;
  end

  assign valid_o = b_vld_q;
  assign data_o  = b_q;

endmodule

// ===== hw/rtl/hsv2rgb_mix.sv =====
// hsv2rgb_mix: stages C and D - channel numerators, sector permutation, x255 scale.
// Depends on hsv2rgb_pkg.

module hsv2rgb_mix import hsv2rgb_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  front_t data_i,
  output logic   valid_o,
  input  logic   ready_i,
  output mix_t   data_o
);

  logic             c_vld_q, c_inv_q;
  logic [2:0][27:0] c_n_q, c_n_d;
  logic             d_vld_q;
  mix_t             d_q, d_d;
  logic             en_c, en_d;
  logic [27:0]      cn, xn, zn;
  logic [36:0]      m [3];

  assign en_d    = !d_vld_q || ready_i;
  assign en_c    = !c_vld_q || en_d;
  assign ready_o = en_c;

  always_comb begin
    zn = 28'(data_i.z) * SEC_UNITS;
    cn = 28'(17'(data_i.z + data_i.sv)) * SEC_UNITS;
    xn = 28'(28'(data_i.sv) * 28'(data_i.k)) + zn;
    unique case (data_i.sec)
      SEC_CX0: c_n_d = {cn, xn, zn};
      SEC_XC0: c_n_d = {xn, cn, zn};
      SEC_0CX: c_n_d = {zn, cn, xn};
      SEC_0XC: c_n_d = {zn, xn, cn};
      SEC_X0C: c_n_d = {xn, zn, cn};
      SEC_C0X: c_n_d = {cn, zn, xn};
      default: c_n_d = {cn, zn, xn};
    endcase
  end

  always_comb begin
    d_d.inv = c_inv_q;
    for (int i = 0; i < 3; i++) begin
      m[i]     = 37'(c_n_q[i]) * CHAN_SCALE + CHAN_BIAS;
      d_d.y[i] = m[i][36:25];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      if (en_c) c_vld_q <= valid_i;
      if (en_d) d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_c && valid_i) begin
      c_inv_q <= data_i.inv;
      c_n_q   <= c_n_d;
    end
    if (en_d && c_vld_q) d_q <= d_d;
  end

  assign valid_o = d_vld_q;
  assign data_o  = d_q;

endmodule

// ===== hw/rtl/hsv2rgb_quant.sv =====
// hsv2rgb_quant: stage E - divide by 15 via reciprocal, pack RGB, output register.
// Depends on hsv2rgb_pkg.

module hsv2rgb_quant import hsv2rgb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  mix_t        data_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [23:0] rgb_o,
  output logic        invalid_o
);

  logic        e_vld_q, e_inv_q;
  logic [23:0] e_rgb_q, e_rgb_d;
  logic        en_e;
  logic [23:0] p [3];

  assign en_e    = !e_vld_q || ready_i;
  assign ready_o = en_e;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p[i] = 24'(data_i.y[i]) * RECIP_15;
    end
    e_rgb_d = data_i.inv ? '0 : {p[2][22:15], p[1][22:15], p[0][22:15]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (en_e) begin
      e_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_e && valid_i) begin
      e_inv_q <= data_i.inv;
      e_rgb_q <= e_rgb_d;
    end
  end

  assign valid_o   = e_vld_q;
  assign rgb_o     = e_rgb_q;
  assign invalid_o = e_inv_q;

endmodule

// ===== hw/rtl/hsv2rgb_checker.sv =====
// hsv2rgb_checker: port-level assertions for hsv_to_rgb_converter, bound to it.
// Depends on hsv2rgb_if through the bind connections.

module hsv2rgb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [23:0] rgb_i,
  input logic        invalid_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && invalid_i |-> rgb_i == 24'd0)
    else $error("invalid item with nonzero rgb");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(rgb_i) && $stable(invalid_i))
    else $error("stalled item changed or dropped");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("item out right after reset");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(in_acc, 1) && !$past(in_acc, 2) && !$past(in_acc, 3) &&
     !$past(in_acc, 4) && !$past(in_acc, 5) &&
     $past(out_ready_i, 1) && $past(out_ready_i, 2) && $past(out_ready_i, 3) &&
     $past(out_ready_i, 4) && $past(out_ready_i, 5)) |-> !out_valid_i)
    else $error("item out with nothing accepted");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (pix_o.valid),
  .out_ready_i (pix_o.ready),
  .rgb_i       (pix_o.rgb),
  .invalid_i   (pix_o.invalid)
);
